### rtl/ncst_pkg.sv
// Package: constants, types and helpers shared by the nearest-cost tree unit
`timescale 1ns / 1ps
package ncst_pkg;
  localparam int unsigned MaxPositions = 1024;
  localparam int unsigned PriceBits    = 30;
  localparam int unsigned LeafBits     = $clog2(MaxPositions);
  localparam int unsigned NodeBits     = LeafBits + 1;
  localparam int unsigned PosBits      = 11;
  localparam int unsigned KeyBits      = PriceBits + 1;
  localparam int unsigned CostBits     = 31;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [LeafBits-1:0]  leaf;
    logic [PosBits-1:0]   pos;
    logic [PosBits-1:0]   n;
    logic [PriceBits-1:0] price;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_LEAF,
    ST_SET_RD,
    ST_SET_WAIT,
    ST_SET_WR,
    ST_Q_PRICE,
    ST_Q_PWAIT,
    ST_Q_STEP,
    ST_Q_WAIT,
    ST_Q_ACC,
    ST_Q_DONE,
    ST_CLEAR
  } state_e;
endpackage

### rtl/ncst_front.sv
// Front end: accepts input beats, checks ranges and turns them into commands
`timescale 1ns / 1ps
module ncst_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [ncst_pkg::PosBits-1:0]   position_i,
  input  logic [ncst_pkg::PriceBits-1:0] price_value_i,
  input  logic                           cfg_we_i,
  input  logic [ncst_pkg::PosBits-1:0]   cfg_wdata_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output ncst_pkg::cmd_t                 cmd_o
);
  import ncst_pkg::*;

  logic [PosBits-1:0] n_q;
  cmd_t               cmd_d;
  cmd_t               fifo_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QueueDepth):0]   cnt_q;
  logic push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= PosBits'(MaxPositions);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) n_q <= PosBits'(1);
      else if (cfg_wdata_i > PosBits'(MaxPositions)) n_q <= PosBits'(MaxPositions);
      else n_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    cmd_d.leaf  = LeafBits'(position_i - PosBits'(1));
    cmd_d.pos   = position_i;
    cmd_d.n     = n_q;
    cmd_d.price = price_value_i;
    if (op_e'(operation_i) == OP_SET) cmd_d.cmd = CMD_SET;
    else if (position_i == '0 || position_i > n_q) cmd_d.cmd = CMD_ERROR;
    else cmd_d.cmd = CMD_QUERY;
  end

  assign in_ready_o  = (cnt_q != QueueDepth[$clog2(QueueDepth):0]);
  // sets outside the store are dropped here
  assign push = in_valid_i && in_ready_o &&
                !(op_e'(operation_i) == OP_SET &&
                  (position_i == '0 || position_i > PosBits'(MaxPositions)));
  assign cmd_valid_o = (cnt_q != '0);
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_o = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{$clog2(QueueDepth){1'b0}}, push} -
               {{$clog2(QueueDepth){1'b0}}, pop};
    end
  end
endmodule

### rtl/ncst_back.sv
// Back end: price store, two min trees and the walk sequencer
`timescale 1ns / 1ps
module ncst_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  ncst_pkg::cmd_t                cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ncst_pkg::CostBits-1:0] best_cost_o
);
  import ncst_pkg::*;

  localparam int unsigned Nodes = 2 * MaxPositions;
  localparam logic [KeyBits-1:0] KeyOnes = '1;
  localparam logic [KeyBits:0]   BigMin  = '1;

  logic [PriceBits-1:0] price_mem [MaxPositions];
  logic [KeyBits-1:0]   lmem [Nodes];
  logic [KeyBits-1:0]   rmem [Nodes];

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [NodeBits-1:0] node_q, node_d;
  logic [NodeBits:0]   l_q, l_d, r_q, r_d;
  logic [NodeBits-1:0] side_node_q, side_node_d;
  logic                side_q, side_d;
  logic                pass_q, pass_d;
  logic [KeyBits-1:0]  lkey_q, lkey_d, rkey_q, rkey_d;
  logic [KeyBits:0]    m_q, m_d;
  logic [KeyBits:0]    best_q, best_d;
  logic [NodeBits-1:0] clr_q, clr_d;

  logic                p_we;
  logic [LeafBits-1:0] p_addr;
  logic [PriceBits-1:0] p_rd_q;
  logic                t_we;
  logic [NodeBits-1:0] t_waddr, t_raddr, t_raddr2;
  logic [KeyBits-1:0]  t_lw, t_rw;
  logic [KeyBits-1:0]  l_rd_q, l_rd2_q, r_rd_q, r_rd2_q;
  logic [CostBits-1:0] out_q, out_d;
  logic                ov_q, ov_d;

  always_ff @(posedge clk_i) begin
    if (p_we) price_mem[p_addr] <= cmd_q.price;
    p_rd_q <= price_mem[p_addr];
    if (t_we) begin
      lmem[t_waddr] <= t_lw;
      rmem[t_waddr] <= t_rw;
    end
    l_rd_q  <= lmem[t_raddr];
    r_rd_q  <= rmem[t_raddr];
    l_rd2_q <= lmem[t_raddr2];
    r_rd2_q <= rmem[t_raddr2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; node_q <= node_d; l_q <= l_d; r_q <= r_d;
    side_node_q <= side_node_d; side_q <= side_d;
    pass_q <= pass_d;
    lkey_q <= lkey_d; rkey_q <= rkey_d; m_q <= m_d; best_q <= best_d;
    out_q <= out_d;
  end

  logic [KeyBits-1:0] tl, tr;
  logic [KeyBits:0]   cand;
  logic [KeyBits:0]   fold;

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; node_d = node_q; l_d = l_q; r_d = r_q;
    side_node_d = side_node_q; side_d = side_q;
    pass_d = pass_q;
    lkey_d = lkey_q; rkey_d = rkey_q; m_d = m_q; best_d = best_q;
    clr_d = clr_q; out_d = out_q; ov_d = ov_q;
    p_we = 1'b0; p_addr = cmd_q.leaf;
    t_we = 1'b0; t_waddr = node_q; t_raddr = {node_q[NodeBits-2:0], 1'b0};
    t_raddr2 = {node_q[NodeBits-2:0], 1'b1};
    t_lw = lkey_q; t_rw = rkey_q;
    cmd_ready_o = 1'b0;
    tl = (l_rd_q < l_rd2_q) ? l_rd_q : l_rd2_q;
    tr = (r_rd_q < r_rd2_q) ? r_rd_q : r_rd2_q;
    cand = {1'b0, (side_q ? r_rd_q : l_rd_q)};
    fold = (cand < m_q) ? cand : m_q;

    if (out_valid_o && out_ready_i) ov_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        t_we = 1'b1; t_waddr = clr_q; t_lw = KeyOnes; t_rw = KeyOnes;
        p_we = 1'b1; p_addr = clr_q[LeafBits-1:0];
        cmd_d.price = '1;
        clr_d = clr_q + 1'b1;
        if (clr_q == NodeBits'(Nodes - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_ready_o = !ov_q;
        if (cmd_valid_i && !ov_q) begin
          cmd_d = cmd_i;
          case (cmd_i.cmd)
            CMD_SET:   state_d = ST_SET_LEAF;
            CMD_QUERY: state_d = ST_Q_PRICE;
            CMD_ERROR: begin
              out_d = '1; ov_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SET_LEAF: begin
        p_we = 1'b1;
        node_d = NodeBits'(MaxPositions) + NodeBits'(cmd_q.leaf);
        lkey_d = KeyBits'(cmd_q.price) + KeyBits'(MaxPositions) - KeyBits'(cmd_q.pos);
        rkey_d = KeyBits'(cmd_q.price) + KeyBits'(cmd_q.pos);
        state_d = ST_SET_WR;
      end
      ST_SET_WR: begin
        t_we = 1'b1;
        node_d = node_q >> 1;
        if (node_q == NodeBits'(1)) state_d = ST_IDLE;
        else state_d = ST_SET_RD;
      end
      ST_SET_RD: state_d = ST_SET_WAIT;
      ST_SET_WAIT: begin
        lkey_d = tl; rkey_d = tr; state_d = ST_SET_WR;
      end
      ST_Q_PRICE: begin
        state_d = ST_Q_PWAIT;
      end
      ST_Q_PWAIT: begin
        best_d = {2'b0, p_rd_q};
        m_d = BigMin;
        if (cmd_q.pos > PosBits'(1)) begin
          side_d = 1'b0;
          l_d = (NodeBits+1)'(MaxPositions);
          r_d = (NodeBits+1)'(MaxPositions) + (NodeBits+1)'(cmd_q.leaf);
          state_d = ST_Q_STEP;
        end else if (cmd_q.pos < cmd_q.n) begin
          side_d = 1'b1;
          l_d = (NodeBits+1)'(MaxPositions) + (NodeBits+1)'(cmd_q.pos);
          r_d = (NodeBits+1)'(MaxPositions) + (NodeBits+1)'(cmd_q.n);
          state_d = ST_Q_STEP;
        end else begin
          state_d = ST_Q_DONE;
        end
      end
      ST_Q_STEP: begin
        // half-open node range; a taken node is read and folded via ST_Q_WAIT and ST_Q_ACC, one level climbed per cycle
        if (l_q < r_q) begin
          if (l_q[0]) begin
            side_node_d = l_q[NodeBits-1:0]; pass_d = 1'b1;
            l_d = l_q + 1'b1;
          end else if (r_q[0]) begin
            side_node_d = r_q[NodeBits-1:0] - 1'b1; pass_d = 1'b1;
            r_d = r_q - 1'b1;
          end else begin
            pass_d = 1'b0;
            l_d = l_q >> 1;
            r_d = r_q >> 1;
          end
          state_d = pass_d ? ST_Q_WAIT : ST_Q_STEP;
        end else begin
          state_d = ST_Q_ACC;
        end
      end
      ST_Q_WAIT: begin
        t_raddr = side_node_q;
        state_d = ST_Q_ACC;
        pass_d = 1'b1;
      end
      ST_Q_ACC: begin
        if (pass_q) begin
          m_d = fold; pass_d = 1'b0; state_d = ST_Q_STEP;
        end else begin
          if (m_q != BigMin) begin
            if (!side_q) cand = m_q - (KeyBits+1)'(MaxPositions) + (KeyBits+1)'(cmd_q.pos);
            else cand = m_q - (KeyBits+1)'(cmd_q.pos);
            if (cand < best_q) best_d = cand;
          end
          m_d = BigMin;
          if (!side_q && cmd_q.pos < cmd_q.n) begin
            side_d = 1'b1;
            l_d = (NodeBits+1)'(MaxPositions) + (NodeBits+1)'(cmd_q.pos);
            r_d = (NodeBits+1)'(MaxPositions) + (NodeBits+1)'(cmd_q.n);
            state_d = ST_Q_STEP;
          end else begin
            state_d = ST_Q_DONE;
          end
        end
      end
      ST_Q_DONE: begin
        out_d = best_q[CostBits-1:0]; ov_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign best_cost_o = out_q;
endmodule

### rtl/nearest_cost_segment_tree_unit.sv
// Top level: nearest-cost point-update range-minimum unit
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | operation_i position_i price_value_i
//  out     | output    | out_valid_o/out_ready_i| best_cost_o
//  cfg     | input     | cfg_we_i               | cfg_wdata_i
// A set writes the leaf and then ten parents, each through ST_SET_RD, ST_SET_WAIT, ST_SET_WR.
// A query takes each covering node through ST_Q_STEP, ST_Q_WAIT and ST_Q_ACC and climbs
// levels in ST_Q_STEP; the back holds the next command while a result waits.
// After reset a clearing pass over all 2048 tree nodes runs before the first item is served.
// The front queue holds two commands and takes beats while the back is busy, until it is full.
`timescale 1ns / 1ps
module nearest_cost_segment_tree_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [ncst_pkg::PosBits-1:0]   position_i,
  input  logic [ncst_pkg::PriceBits-1:0] price_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ncst_pkg::CostBits-1:0]  best_cost_o,
  input  logic                           cfg_we_i,
  input  logic [ncst_pkg::PosBits-1:0]   cfg_wdata_i
);
  import ncst_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  ncst_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .position_i,
    .price_value_i, .cfg_we_i, .cfg_wdata_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  ncst_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .best_cost_o
  );
endmodule

### rtl/ncst_checker.sv
// Port assertions for the nearest-cost unit, bound to the top level
`timescale 1ns / 1ps
module ncst_assert (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ncst_pkg::CostBits-1:0] best_cost_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_cost_o))
    else $error("result beat changed while stalled");
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result beat during reset");
  a_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_ready_o))
    else $error("input ready unknown");
  a_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(out_valid_o))
    else $error("result valid unknown");
  a_cost_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(best_cost_o))
    else $error("result beat carries unknown bits");
endmodule

bind nearest_cost_segment_tree_unit ncst_assert u_ncst_assert (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
  .out_valid_o, .out_ready_i, .best_cost_o
);

### verif/ncst_checker.sv
// Checker for the nearest-cost tree unit: watches the channels, predicts each cost, compares
`timescale 1ns / 1ps
module ncst_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           operation_i,
  input  logic [ncst_pkg::PosBits-1:0]   position_i,
  input  logic [ncst_pkg::PriceBits-1:0] price_value_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [ncst_pkg::CostBits-1:0]  best_cost_i,
  input  logic                           cfg_we_i,
  input  logic [ncst_pkg::PosBits-1:0]   cfg_wdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import ncst_pkg::*;

  localparam logic [CostBits-1:0] CostError = '1;

  logic [PriceBits-1:0] price_copy [MaxPositions];
  logic [PosBits-1:0]   span;
  logic [CostBits-1:0]  cost_queue [$];
  int                   fails;

  assign fail_count_o = fails;
  assign pending_o    = cost_queue.size();

  // cheapest price plus distance over positions 1..span, unset entries at all ones
  function automatic logic [CostBits-1:0] cheapest(input logic [PosBits-1:0] k);
    logic [CostBits-1:0] best;
    logic [CostBits-1:0] cand;
    int                  j;
    if (k < 1 || k > span) return CostError;
    best = CostError;
    for (j = 1; j <= span; j++) begin
      cand = CostBits'(price_copy[j-1]) + CostBits'(j > k ? j - k : k - j);
      if (cand < best) best = cand;
    end
    return best;
  endfunction

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxPositions; i++) price_copy[i] = '1;
      span = PosBits'(MaxPositions);
      cost_queue.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (cost_queue.size() == 0) begin
          report($sformatf("unexpected result beat, best_cost %0d", best_cost_i));
        end else begin
          if (best_cost_i !== cost_queue[0])
            report($sformatf("best_cost %0d, expected %0d", best_cost_i, cost_queue[0]));
          void'(cost_queue.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (op_e'(operation_i) == OP_SET) begin
          if (position_i >= 1 && position_i <= MaxPositions)
            price_copy[position_i-1] = price_value_i;
        end else begin
          cost_queue.push_back(cheapest(position_i));
        end
      end
      if (cfg_we_i) begin
        if (cfg_wdata_i < 1) span = PosBits'(1);
        else if (cfg_wdata_i > MaxPositions) span = PosBits'(MaxPositions);
        else span = cfg_wdata_i;
      end
    end
  end
endmodule

### verif/tb_top.sv
// Testbench top: stimulus, receiver stalls and verdict for the nearest-cost tree unit
`timescale 1ns / 1ps
module tb_top;
  import ncst_pkg::*;

  localparam int Limit = 4000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 operation_i = 1'b0;
  logic [PosBits-1:0]   position_i = '0;
  logic [PriceBits-1:0] price_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CostBits-1:0]  best_cost_o;
  logic                 cfg_we_i = 1'b0;
  logic [PosBits-1:0]   cfg_wdata_i = '0;
  int                   fail_count;
  int                   pending;
  int                   burst_left = 0;
  int                   span = MaxPositions;
  int                   hold_req = 0;
  int                   sets = 0, queries = 0, settings = 0;
  longint               cycles = 0;

  always #2 clk_i = ~clk_i;

  nearest_cost_segment_tree_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .position_i, .price_value_i,
    .out_valid_o, .out_ready_i, .best_cost_o, .cfg_we_i, .cfg_wdata_i
  );

  ncst_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .position_i,
    .price_value_i, .out_valid_i(out_valid_o), .out_ready_i, .best_cost_i(best_cost_o),
    .cfg_we_i, .cfg_wdata_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: a randomly re-drawn stall pattern, plus one long hold-off on request
  initial begin
    int mode;
    int hold;
    mode = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (cycles % 200 == 0) mode = $urandom_range(0, 3);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 7) == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send(input op_e op, input logic [PosBits-1:0] pos,
                      input logic [PriceBits-1:0] price);
    int  gap;
    bit  taken;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    position_i    <= pos;
    price_value_i <= price;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    burst_left--;
    if (op == OP_SET) sets++;
    else queries++;
  endtask

  task automatic drain();
    int p;
    in_valid_i <= 1'b0;
    burst_left = 0;
    do begin
      @(negedge clk_i);
      p = pending;
      @(posedge clk_i);
    end while (p != 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_span(input logic [PosBits-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    span = v < 1 ? 1 : (v > MaxPositions ? MaxPositions : v);
    settings++;
  endtask

  function automatic logic [PriceBits-1:0] pick_price();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return PriceBits'($urandom());
      2: return '0;
      default: return PriceBits'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [PosBits-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return PosBits'($urandom());
      1: return $urandom_range(0, 1) ? '0 : PosBits'(span + 1);
      default: return PosBits'($urandom_range(1, span));
    endcase
  endfunction

  initial begin
    logic [PosBits-1:0] spans [10];
    int                 n;
    spans = '{1024, 1, 2, 0, 2047, 37, 0, 1024, 5, 200};
    spans[6] = PosBits'($urandom());
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edges of the store and of the range, extreme prices
    send(OP_QUERY, 1, 0);
    send(OP_QUERY, 0, 0);
    send(OP_SET, 1, '1);
    send(OP_SET, 1024, 0);
    send(OP_SET, 0, 5);
    send(OP_SET, 1025, 7);
    send(OP_SET, 2047, '1);
    send(OP_QUERY, 1, '1);
    send(OP_QUERY, 1024, 0);
    send(OP_QUERY, 2047, 0);
    send(OP_SET, 512, 3);
    send(OP_SET, 513, 0);
    send(OP_QUERY, 600, 0);
    send(OP_QUERY, 100, 0);
    send(OP_QUERY, 1025, 0);
    drain();
    set_span(2047);
    send(OP_QUERY, 1024, 0);
    drain();
    set_span(1000);
    send(OP_SET, 1010, 0);
    send(OP_QUERY, 1000, 0);
    send(OP_QUERY, 1001, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      set_span(spans[ph]);
      if (ph == 2) hold_req = 3000;
      n = 150;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) send(OP_SET, pick_pos(), pick_price());
        else send(OP_QUERY, pick_pos(), PriceBits'($urandom()));
      end
      drain();
    end

    $display("Covered %0d sets and %0d queries over %0d range settings,", sets, queries,
             settings);
    $display("with sender bursts, receiver stalls and one long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
